// ----- sv/ubx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the UBX frame parser.
// No dependencies; imported by every module of the block.
package ubx_pkg;

  localparam int N_ACCEPT  = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = 3'd7;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [15:0] ACCEPT_RESET [N_ACCEPT] = '{
    16'h0701, 16'h3B01, 16'h0105, 16'h0005, 16'h8A06, 16'h8B06, 16'h8C06
  };
  localparam logic [N_ACCEPT-1:0] MASK_RESET = 7'h7F;

  typedef enum logic [6:0] {
    PH_SYNC1   = 7'b0000001,
    PH_SYNC2   = 7'b0000010,
    PH_HEADER  = 7'b0000100,
    PH_LENGTH  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CKA     = 7'b0100000,
    PH_CKB     = 7'b1000000
  } ubx_phase_t;

  typedef struct packed {
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  payload_data;
    logic        frame_ok;
    logic [15:0] frame_header;
    logic [15:0] frame_length;
  } ubx_result_t;

endpackage
`default_nettype wire

// ----- sv/ubx_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accepted class/id words, enable mask, and the header match against them.
// Depends on ubx_pkg.
module ubx_cfg_regs import ubx_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [15:0]          wr_data,
  input  wire logic [15:0]          cand_header,
  output logic                      header_match
);

  logic [15:0]         accept_r [N_ACCEPT];
  logic [N_ACCEPT-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_ACCEPT; k++) begin
        accept_r[k] <= ACCEPT_RESET[k];
      end
      mask_r <= MASK_RESET;
    end else if (wr_en) begin
      for (int k = 0; k < N_ACCEPT; k++) begin
        if (wr_index == CFG_IDX_W'(k)) begin
          accept_r[k] <= wr_data;
        end
      end
      if (wr_index == CFG_IDX_MASK) begin
        mask_r <= wr_data[N_ACCEPT-1:0];
      end
    end
  end

  always_comb begin
    header_match = 1'b0;
    for (int k = 0; k < N_ACCEPT; k++) begin
      if (mask_r[k] && (accept_r[k] == cand_header)) begin
        header_match = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/ubx_parse_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Parser state and single-byte step logic with running Fletcher sums.
// Depends on ubx_pkg; header acceptance comes from ubx_cfg_regs.
module ubx_parse_core import ubx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        header_match,
  output logic [15:0]      cand_header,
  output ubx_result_t      result
);

  ubx_phase_t  phase_r, phase_nxt, hunt_phase;
  logic [15:0] cnt_r, cnt_nxt, cnt_inc;
  logic [15:0] hdr_r, hdr_nxt;
  logic [15:0] len_r, len_nxt, len_full;
  logic [7:0]  sum_a_r, sum_a_nxt, sum_a_add;
  logic [7:0]  sum_b_r, sum_b_nxt, sum_b_add;
  logic        ck_a_ok;

  assign cand_header = {rx_byte, hdr_r[7:0]};
  assign len_full    = {rx_byte, len_r[7:0]};
  assign sum_a_add   = sum_a_r + rx_byte;
  assign sum_b_add   = sum_b_r + sum_a_add;
  assign cnt_inc     = cnt_r + 16'd1;
  assign hunt_phase  = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
  assign ck_a_ok     = (rx_byte == sum_a_r);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    len_nxt   = len_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    result    = '0;
    case (phase_r)
      PH_SYNC1: begin
        phase_nxt = hunt_phase;
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          cnt_nxt   = 16'd0;
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = hunt_phase;
        end
      end
      PH_HEADER: begin
        if (cnt_r == 16'd0) begin
          // first header byte restarts the sums
          hdr_nxt   = {8'h00, rx_byte};
          sum_a_nxt = rx_byte;
          sum_b_nxt = rx_byte;
          cnt_nxt   = 16'd1;
        end else begin
          hdr_nxt = cand_header;
          if (header_match) begin
            sum_a_nxt = sum_a_add;
            sum_b_nxt = sum_b_add;
            cnt_nxt   = 16'd0;
            phase_nxt = PH_LENGTH;
          end else begin
            phase_nxt = hunt_phase;
          end
        end
      end
      PH_LENGTH: begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        if (cnt_r == 16'd0) begin
          len_nxt = {8'h00, rx_byte};
          cnt_nxt = 16'd1;
        end else begin
          len_nxt   = len_full;
          cnt_nxt   = 16'd0;
          phase_nxt = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (cnt_r < len_r) begin
          result.payload_valid = 1'b1;
          result.payload_index = cnt_r;
          result.payload_data  = rx_byte;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          cnt_nxt   = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = PH_CKA;
          end
        end else begin
          phase_nxt = ck_a_ok ? PH_CKB : hunt_phase;
        end
      end
      PH_CKA: begin
        phase_nxt = ck_a_ok ? PH_CKB : hunt_phase;
      end
      PH_CKB: begin
        phase_nxt       = PH_SYNC1;
        result.frame_ok = (rx_byte == sum_b_r);
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase
    result.frame_header = hdr_nxt;
    result.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      cnt_r   <= '0;
      hdr_r   <= '0;
      len_r   <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      len_r   <= len_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ubx_frame_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// UBX frame parser, top level. Depends on ubx_pkg, ubx_cfg_regs, ubx_parse_core.
//
// Input channel: one received byte per transaction (in_valid / in_stall /
// in_rx_data). Every byte yields exactly one result transaction on the out_
// channel: a payload byte with its index when it is one, frame_ok on a
// matching CK_B, and the current class/id and length words.
// Path: a byte accepted on in_ is held in the input register; the parse step
// then writes its result into the result register that drives out_.
// Throughput: one byte per cycle while out_ is not stalled; the parse step is a
// single pass of logic between the input register and the result register.
// Stall: while out_stall holds a pending result, the input register keeps its
// byte and in_stall rises only when that register is also full.
// Configuration: cfg_index 0..6 write accept words, 7 writes the enable mask;
// cfg_ready is always high. Write only while the block is idle.
// Reset (rst_n low, synchronous): parser back to sync hunting, sums and words
// cleared, accept words and mask to their defaults, both channels empty.
module ubx_frame_parser import ubx_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_payload_valid,
  output logic [15:0]               out_payload_index,
  output logic [7:0]                out_payload_data,
  output logic                      out_frame_ok,
  output logic [15:0]               out_frame_header,
  output logic [15:0]               out_frame_length,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  ubx_result_t out_r, step_result;
  logic        in_accept, advance;
  logic        header_match;
  logic [15:0] cand_header;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  ubx_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_valid && cfg_ready),
    .wr_index     (cfg_index),
    .wr_data      (cfg_data),
    .cand_header  (cand_header),
    .header_match (header_match)
  );

  ubx_parse_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .rx_byte      (s1_data_r),
    .header_match (header_match),
    .cand_header  (cand_header),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_rx_data;
    end
    if (advance) begin
      out_r <= step_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = out_r.payload_valid;
  assign out_payload_index = out_r.payload_index;
  assign out_payload_data  = out_r.payload_data;
  assign out_frame_ok      = out_r.frame_ok;
  assign out_frame_header  = out_r.frame_header;
  assign out_frame_length  = out_r.frame_length;

endmodule
`default_nettype wire
